// ===== src/batch_to_space_address_map_assert.svh =====
// assertion macros for the batch-to-space address map checker
// expects clk and rst_n in the scope where a macro is used
`ifndef BATCH_TO_SPACE_ADDRESS_MAP_ASSERT_SVH
`define BATCH_TO_SPACE_ADDRESS_MAP_ASSERT_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define B2S_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising edge, off during reset
`define B2S_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/b2s_pkg.sv =====
// shared constants, codes and payload types for the batch-to-space address map
// no dependencies; every other file but the assertion header uses it
`default_nettype none

package b2s_pkg;

    localparam int DIM_BITS      = 16;
    localparam int BLK_BITS      = 8;
    localparam int CROP_BITS     = 16;
    localparam int WORD_BITS     = 32;
    localparam int OFF_BITS      = 32;
    localparam int CFG_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;
    localparam int LAYOUT_BITS   = 2;
    localparam int DEN_BITS      = (DIM_BITS > BLK_BITS) ? DIM_BITS : BLK_BITS;
    localparam int DIV_STAGES    = DIM_BITS;
    localparam int IDX_STAGES    = 6;
    localparam int PIPE_DEPTH    = 2 * DIV_STAGES + IDX_STAGES;
    localparam int FLIGHT_BITS   = $clog2(PIPE_DEPTH + 1) + 1;

    typedef enum logic [LAYOUT_BITS-1:0] {
        LAYOUT_RANK3 = 2'd0,
        LAYOUT_NHWC  = 2'd1,
        LAYOUT_NCHW  = 2'd2
    } layout_t;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_LAYOUT_MODE   = 3'd0,
        REG_OUT_BATCH     = 3'd1,
        REG_OUT_HEIGHT    = 3'd2,
        REG_OUT_WIDTH     = 3'd3,
        REG_CHANNEL_COUNT = 3'd4,
        REG_BLOCK_HEIGHT  = 3'd5,
        REG_BLOCK_WIDTH   = 3'd6,
        REG_CROP_AMOUNTS  = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [DIM_BITS-1:0]  in_batch;
        logic [DIM_BITS-1:0]  in_row;
        logic [DIM_BITS-1:0]  in_col;
        logic [DIM_BITS-1:0]  in_channel;
        logic [WORD_BITS-1:0] element_in;
    } in_item_t;

    typedef struct packed {
        logic                 write_enable;
        logic [OFF_BITS-1:0]  out_offset;
        logic [WORD_BITS-1:0] element_out;
    } out_item_t;

    // effective configuration, rank-three overrides already applied
    typedef struct packed {
        logic                 rank3;
        logic                 nchw;
        logic [DIM_BITS-1:0]  nb;
        logic [DIM_BITS-1:0]  oh_n;
        logic [DIM_BITS-1:0]  ow_n;
        logic [DIM_BITS-1:0]  c_n;
        logic [BLK_BITS-1:0]  bh;
        logic [BLK_BITS-1:0]  bw;
        logic [CROP_BITS-1:0] crop_top;
        logic [CROP_BITS-1:0] crop_left;
    } cfg_t;

    // everything one word carries down the pipe
    typedef struct packed {
        logic [DIM_BITS-1:0]  row;
        logic [DIM_BITS-1:0]  col;
        logic [DIM_BITS-1:0]  ch;
        logic [DIM_BITS-1:0]  ob;
        logic [DIM_BITS-1:0]  slot_row;
        logic [DIM_BITS-1:0]  slot_col;
        logic [WORD_BITS-1:0] data;
        logic [OFF_BITS-1:0]  row_pos;
        logic [OFF_BITS-1:0]  col_pos;
        logic [OFF_BITS-1:0]  acc;
        logic                 we;
    } work_t;

    typedef struct packed {
        logic [DEN_BITS-1:0] rem;
        logic [DIM_BITS-1:0] num;
    } div_t;

    // one restoring-division step: shift in the next numerator bit, subtract if it fits
    function automatic div_t div_step(input div_t cur, input logic [DEN_BITS-1:0] den);
        logic [DEN_BITS:0] trial;
        logic [DEN_BITS:0] diff;
        logic              fits;
        div_t              res;
        trial = {cur.rem, cur.num[DIM_BITS-1]};
        diff  = trial - {1'b0, den};
        fits  = (trial >= {1'b0, den});
        res.rem = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        res.num = {cur.num[DIM_BITS-2:0], fits};
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/b2s_in_if.sv =====
// input channel: valid/ready handshake carrying one tensor element word
// depends on b2s_pkg
`default_nettype none

interface b2s_in_if;
    logic               valid;
    logic               ready;
    b2s_pkg::in_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/b2s_out_if.sv =====
// output channel: valid/ready handshake carrying one offset/data word
// depends on b2s_pkg
`default_nettype none

interface b2s_out_if;
    logic               valid;
    logic               ready;
    b2s_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/b2s_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage, side data rides along
// depends on b2s_pkg
`default_nettype none

module b2s_div_pipe (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [b2s_pkg::DIM_BITS-1:0]     num,
    input  wire  [b2s_pkg::DEN_BITS-1:0]     den,
    input  b2s_pkg::work_t                   side_in,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [b2s_pkg::DIM_BITS-1:0]     quot,
    output logic [b2s_pkg::DIM_BITS-1:0]     rem,
    output b2s_pkg::work_t                   side_out
);
    import b2s_pkg::*;

    logic  [DIV_STAGES:0] valid_link;
    logic  [DIV_STAGES:0] ready_link;
    div_t                 div_link  [DIV_STAGES+1];
    work_t                side_link [DIV_STAGES+1];

    assign valid_link[0]          = in_valid;
    assign div_link[0].rem        = '0;
    assign div_link[0].num        = num;
    assign side_link[0]           = side_in;
    assign ready_link[DIV_STAGES] = out_ready;
    assign in_ready               = ready_link[0];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic  valid_reg;
        div_t  div_reg;
        div_t  div_next;
        work_t side_reg;

        assign div_next      = div_step(div_link[k], den);
        assign ready_link[k] = !valid_reg || ready_link[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (ready_link[k])
            begin
                valid_reg <= valid_link[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ready_link[k] && valid_link[k])
            begin
                div_reg  <= div_next;
                side_reg <= side_link[k];
            end
        end

        assign valid_link[k+1] = valid_reg;
        assign div_link[k+1]   = div_reg;
        assign side_link[k+1]  = side_reg;
    end

    // remainder never exceeds the numerator, so it fits the index width
    assign out_valid = valid_link[DIV_STAGES];
    assign quot      = div_link[DIV_STAGES].num;
    assign rem       = div_link[DIV_STAGES].rem[DIM_BITS-1:0];
    assign side_out  = side_link[DIV_STAGES];

endmodule

`default_nettype wire

// ===== src/b2s_index_calc.sv =====
// position, crop test and layout offset: scale, add/crop, compare, three multiply-adds
// depends on b2s_pkg
`default_nettype none

module b2s_index_calc (
    input  wire                 clk,
    input  wire                 rst_n,
    input  b2s_pkg::cfg_t       cfg,
    input  wire                 in_valid,
    output logic                in_ready,
    input  b2s_pkg::work_t      work_in,
    output logic                out_valid,
    input  wire                 out_ready,
    output b2s_pkg::work_t      work_out
);
    import b2s_pkg::*;

    logic  [IDX_STAGES:0] valid_link;
    logic  [IDX_STAGES:0] ready_link;
    work_t                work_link  [IDX_STAGES+1];
    work_t                stage_next [IDX_STAGES];

    logic [DIM_BITS-1:0] mul4;
    logic [OFF_BITS-1:0] add4;
    logic [DIM_BITS-1:0] mul5;
    logic [OFF_BITS-1:0] add5;

    assign valid_link[0]          = in_valid;
    assign work_link[0]           = work_in;
    assign ready_link[IDX_STAGES] = out_ready;
    assign in_ready               = ready_link[0];

    assign mul4 = cfg.rank3 ? cfg.c_n : (cfg.nchw ? cfg.oh_n : cfg.ow_n);
    assign add4 = cfg.rank3 ? OFF_BITS'(work_link[4].ch)
                : (cfg.nchw ? work_link[4].row_pos : work_link[4].col_pos);
    assign mul5 = cfg.nchw ? cfg.ow_n : cfg.c_n;
    assign add5 = cfg.nchw ? work_link[5].col_pos : OFF_BITS'(work_link[5].ch);

    always_comb
    begin
        for (int k = 0; k < IDX_STAGES; k++)
        begin
            stage_next[k] = work_link[k];
        end

        // scale by block size
        stage_next[0].row_pos = OFF_BITS'(work_link[0].row) * OFF_BITS'(cfg.bh);
        stage_next[0].col_pos = cfg.rank3 ? '0
                              : OFF_BITS'(work_link[0].col) * OFF_BITS'(cfg.bw);

        // add slot part, remove crop, wrapping
        stage_next[1].row_pos = work_link[1].row_pos + OFF_BITS'(work_link[1].slot_row)
                              - OFF_BITS'(cfg.crop_top);
        stage_next[1].col_pos = work_link[1].col_pos + OFF_BITS'(work_link[1].slot_col)
                              - OFF_BITS'(cfg.crop_left);

        stage_next[2].we = (work_link[2].row_pos < OFF_BITS'(cfg.oh_n))
                        && (work_link[2].col_pos < OFF_BITS'(cfg.ow_n));

        stage_next[3].acc = OFF_BITS'(work_link[3].ob) * OFF_BITS'(cfg.nchw ? cfg.c_n : cfg.oh_n)
                          + (cfg.nchw ? OFF_BITS'(work_link[3].ch) : work_link[3].row_pos);

        stage_next[4].acc = work_link[4].acc * OFF_BITS'(mul4) + add4;

        if (!cfg.rank3)
        begin
            stage_next[5].acc = work_link[5].acc * OFF_BITS'(mul5) + add5;
        end
        if (!work_link[5].we)
        begin
            stage_next[5].acc = '0;
        end
    end

    for (genvar k = 0; k < IDX_STAGES; k++)
    begin : g_stage
        logic  valid_reg;
        work_t work_reg;

        assign ready_link[k] = !valid_reg || ready_link[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (ready_link[k])
            begin
                valid_reg <= valid_link[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ready_link[k] && valid_link[k])
            begin
                work_reg <= stage_next[k];
            end
        end

        assign valid_link[k+1] = valid_reg;
        assign work_link[k+1]  = work_reg;
    end

    assign out_valid = valid_link[IDX_STAGES];
    assign work_out  = work_link[IDX_STAGES];

endmodule

`default_nettype wire

// ===== src/batch_to_space_address_map.sv =====
// top level: configuration registers and the divider / index pipeline
// depends on b2s_pkg, b2s_in_if, b2s_out_if, b2s_div_pipe, b2s_index_calc
`default_nettype none

// Batch-to-space address generator. Each input word is one tensor element
// (batch, row, column, channel, data); each output word gives the flat
// output offset, a write flag (clear when the element is cropped away, with
// offset zero) and the data unchanged. One word enters per clock and one
// leaves per clock when the sink is ready; each word passes through two
// restoring dividers that resolve one quotient bit per stage (batch by
// out_batch, then slot by block_width), then six stages of scaling, crop
// test and three multiply-adds. Each stage holds its word while the sink
// stalls and bubbles close up, so input keeps flowing while a result
// waits. Write registers only while no words are in flight.
module batch_to_space_address_map (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_write,
    input  wire  [b2s_pkg::REG_IDX_BITS-1:0]     cfg_index,
    input  wire  [b2s_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    b2s_in_if.sink                               elements,
    b2s_out_if.source                            results
);
    import b2s_pkg::*;

    logic [LAYOUT_BITS-1:0]   layout_reg;
    logic [DIM_BITS-1:0]      out_batch_reg;
    logic [DIM_BITS-1:0]      out_height_reg;
    logic [DIM_BITS-1:0]      out_width_reg;
    logic [DIM_BITS-1:0]      channels_reg;
    logic [BLK_BITS-1:0]      block_h_reg;
    logic [BLK_BITS-1:0]      block_w_reg;
    logic [2*CROP_BITS-1:0]   crops_reg;

    cfg_t  cfg;
    work_t side_a;
    work_t side_a_out;
    work_t side_b;
    work_t side_b_out;
    work_t side_c;
    work_t work_done;

    logic                a_out_valid;
    logic                b_in_ready;
    logic                b_out_valid;
    logic                c_in_ready;
    logic                c_out_valid;
    logic [DIM_BITS-1:0] quot_a;
    logic [DIM_BITS-1:0] rem_a;
    logic [DIM_BITS-1:0] quot_b;
    logic [DIM_BITS-1:0] rem_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg     <= LAYOUT_NHWC;
            out_batch_reg  <= DIM_BITS'(1);
            out_height_reg <= DIM_BITS'(1);
            out_width_reg  <= DIM_BITS'(1);
            channels_reg   <= DIM_BITS'(1);
            block_h_reg    <= BLK_BITS'(1);
            block_w_reg    <= BLK_BITS'(1);
            crops_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LAYOUT_MODE:   layout_reg     <= cfg_data[LAYOUT_BITS-1:0];
                REG_OUT_BATCH:     out_batch_reg  <= cfg_data[DIM_BITS-1:0];
                REG_OUT_HEIGHT:    out_height_reg <= cfg_data[DIM_BITS-1:0];
                REG_OUT_WIDTH:     out_width_reg  <= cfg_data[DIM_BITS-1:0];
                REG_CHANNEL_COUNT: channels_reg   <= cfg_data[DIM_BITS-1:0];
                REG_BLOCK_HEIGHT:  block_h_reg    <= cfg_data[BLK_BITS-1:0];
                REG_BLOCK_WIDTH:   block_w_reg    <= cfg_data[BLK_BITS-1:0];
                REG_CROP_AMOUNTS:  crops_reg      <= cfg_data[2*CROP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // rank three forces unit width and block width and no left crop
    always_comb
    begin
        cfg.rank3     = (layout_reg == LAYOUT_RANK3);
        cfg.nchw      = (layout_reg == LAYOUT_NCHW);
        cfg.nb        = (out_batch_reg == '0) ? DIM_BITS'(1) : out_batch_reg;
        cfg.oh_n      = out_height_reg;
        cfg.ow_n      = cfg.rank3 ? DIM_BITS'(1) : out_width_reg;
        cfg.c_n       = channels_reg;
        cfg.bh        = block_h_reg;
        cfg.bw        = (cfg.rank3 || block_w_reg == '0) ? BLK_BITS'(1) : block_w_reg;
        cfg.crop_top  = crops_reg[2*CROP_BITS-1:CROP_BITS];
        cfg.crop_left = cfg.rank3 ? '0 : crops_reg[CROP_BITS-1:0];
    end

    always_comb
    begin
        side_a      = '0;
        side_a.row  = elements.payload.in_row;
        side_a.col  = elements.payload.in_col;
        side_a.ch   = elements.payload.in_channel;
        side_a.data = elements.payload.element_in;

        side_b    = side_a_out;
        side_b.ob = rem_a;

        side_c          = side_b_out;
        side_c.slot_row = quot_b;
        side_c.slot_col = rem_b;
    end

    // batch split: quotient is the spatial slot, remainder the output batch
    b2s_div_pipe u_div_batch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (elements.valid),
        .in_ready  (elements.ready),
        .num       (elements.payload.in_batch),
        .den       (DEN_BITS'(cfg.nb)),
        .side_in   (side_a),
        .out_valid (a_out_valid),
        .out_ready (b_in_ready),
        .quot      (quot_a),
        .rem       (rem_a),
        .side_out  (side_a_out)
    );

    // slot split into row and column parts
    b2s_div_pipe u_div_slot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_out_valid),
        .in_ready  (b_in_ready),
        .num       (quot_a),
        .den       (DEN_BITS'(cfg.bw)),
        .side_in   (side_b),
        .out_valid (b_out_valid),
        .out_ready (c_in_ready),
        .quot      (quot_b),
        .rem       (rem_b),
        .side_out  (side_b_out)
    );

    b2s_index_calc u_index (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (b_out_valid),
        .in_ready  (c_in_ready),
        .work_in   (side_c),
        .out_valid (c_out_valid),
        .out_ready (results.ready),
        .work_out  (work_done)
    );

    assign results.valid                = c_out_valid;
    assign results.payload.write_enable = work_done.we;
    assign results.payload.out_offset   = work_done.acc;
    assign results.payload.element_out  = work_done.data;

endmodule

`default_nettype wire

// ===== src/b2s_checker.sv =====
// port-level checker for the batch-to-space address map, bound to the top level
// depends on b2s_pkg and batch_to_space_address_map_assert.svh
`default_nettype none
`include "batch_to_space_address_map_assert.svh"

module b2s_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               in_valid,
    input wire                               in_ready,
    input wire                               out_valid,
    input wire                               out_ready,
    input wire                               write_enable,
    input wire [b2s_pkg::OFF_BITS-1:0]       out_offset,
    input wire [b2s_pkg::WORD_BITS-1:0]      element_out
);
    import b2s_pkg::*;

    logic [FLIGHT_BITS-1:0] flight_reg;
    logic [FLIGHT_BITS-1:0] flight_next;
    logic                   in_take;
    logic                   out_take;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    always_comb
    begin
        flight_next = flight_reg;
        if (in_take && !out_take)
        begin
            flight_next = flight_reg + FLIGHT_BITS'(1);
        end
        else if (out_take && !in_take)
        begin
            flight_next = flight_reg - FLIGHT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg <= '0;
        end
        else
        begin
            flight_reg <= flight_next;
        end
    end

    `B2S_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_offset) && $stable(element_out) && $stable(write_enable),
        "stalled output word changed")
    `B2S_ASSERT_NOW(a_out_drop, $fell(out_valid), $past(out_ready),
        "output word withdrawn without handshake")
    `B2S_ASSERT_NOW(a_cropped_zero, out_valid && !write_enable, out_offset == '0,
        "cropped word carries nonzero offset")
    `B2S_ASSERT_NOW(a_no_phantom, out_valid,
        flight_reg != '0 && flight_reg <= FLIGHT_BITS'(PIPE_DEPTH),
        "output word without matching input word")

endmodule

bind batch_to_space_address_map b2s_checker u_b2s_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (elements.valid),
    .in_ready     (elements.ready),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .write_enable (results.payload.write_enable),
    .out_offset   (results.payload.out_offset),
    .element_out  (results.payload.element_out)
);

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for batch_to_space_address_map: directed and random tensor elements,
// results checked in order against an offset predictor held in a small scoreboard class
// depends on b2s_pkg, b2s_in_if, b2s_out_if and the rtl top level
`default_nettype none

module tb;
    import b2s_pkg::*;

    localparam logic [1:0] LAYOUT_NHWC_ALIAS = 2'd3;

    class offset_scoreboard;
        logic [1:0]  layout;
        logic [15:0] out_batch;
        logic [15:0] out_height;
        logic [15:0] out_width;
        logic [15:0] channels;
        logic [7:0]  block_h;
        logic [7:0]  block_w;
        logic [31:0] crops;
        out_item_t   expected_words[$];
        int          errors;

        function new();
            layout     = LAYOUT_NHWC;
            out_batch  = 16'd1;
            out_height = 16'd1;
            out_width  = 16'd1;
            channels   = 16'd1;
            block_h    = 8'd1;
            block_w    = 8'd1;
            crops      = '0;
            errors     = 0;
        endfunction

        function void set_reg(reg_index_t idx, logic [31:0] value);
            case (idx)
                REG_LAYOUT_MODE:   layout     = value[1:0];
                REG_OUT_BATCH:     out_batch  = value[15:0];
                REG_OUT_HEIGHT:    out_height = value[15:0];
                REG_OUT_WIDTH:     out_width  = value[15:0];
                REG_CHANNEL_COUNT: channels   = value[15:0];
                REG_BLOCK_HEIGHT:  block_h    = value[7:0];
                REG_BLOCK_WIDTH:   block_w    = value[7:0];
                default:           crops      = value;
            endcase
        endfunction

        function out_item_t map_element(in_item_t e);
            logic        rank3;
            logic [31:0] nb;
            logic [31:0] bw;
            logic [31:0] oh_n;
            logic [31:0] ow_n;
            logic [31:0] col;
            logic [31:0] ctop;
            logic [31:0] cleft;
            logic [31:0] ob;
            logic [31:0] slot;
            logic [31:0] row_pos;
            logic [31:0] col_pos;
            logic [31:0] off;
            out_item_t   r;
            rank3   = (layout == LAYOUT_RANK3);
            nb      = (out_batch == 16'd0) ? 32'd1 : 32'(out_batch);
            bw      = (rank3 || block_w == 8'd0) ? 32'd1 : 32'(block_w);
            oh_n    = 32'(out_height);
            ow_n    = rank3 ? 32'd1 : 32'(out_width);
            col     = rank3 ? 32'd0 : 32'(e.in_col);
            ctop    = 32'(crops[31:16]);
            cleft   = rank3 ? 32'd0 : 32'(crops[15:0]);
            ob      = 32'(e.in_batch) % nb;
            slot    = 32'(e.in_batch) / nb;
            row_pos = 32'(e.in_row) * 32'(block_h) + slot / bw - ctop;
            col_pos = col * bw + slot % bw - cleft;
            off     = '0;
            r.write_enable = (row_pos < oh_n) && (col_pos < ow_n);
            if (r.write_enable) begin
                if (rank3)
                    off = (ob * oh_n + row_pos) * 32'(channels) + 32'(e.in_channel);
                else if (layout == LAYOUT_NCHW)
                    off = ((ob * 32'(channels) + 32'(e.in_channel)) * oh_n + row_pos) * ow_n
                          + col_pos;
                else
                    off = ((ob * oh_n + row_pos) * ow_n + col_pos) * 32'(channels)
                          + 32'(e.in_channel);
            end
            r.out_offset  = off;
            r.element_out = e.element_in;
            return r;
        endfunction

        function void note_element(in_item_t e);
            expected_words.push_back(map_element(e));
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_words.size() == 0) begin
                errors++;
                $error("result word with no element pending");
                return;
            end
            want = expected_words.pop_front();
            if (got.write_enable !== want.write_enable) begin
                errors++;
                $error("write_enable: expected %0d, got %0d", want.write_enable,
                       got.write_enable);
            end
            if (got.out_offset !== want.out_offset) begin
                errors++;
                $error("out_offset: expected %0h, got %0h", want.out_offset, got.out_offset);
            end
            if (got.element_out !== want.element_out) begin
                errors++;
                $error("element_out: expected %0h, got %0h", want.element_out,
                       got.element_out);
            end
        endfunction

        function int outstanding();
            return expected_words.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_write;
    logic [REG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    bit                       stall_on = 1'b1;
    bit                       sender_idle = 1'b1;
    int                       hold_request = 0;
    offset_scoreboard         offsets = new();

    b2s_in_if  elements_if();
    b2s_out_if results_if();

    batch_to_space_address_map i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .elements  (elements_if),
        .results   (results_if)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic in_item_t element(logic [15:0] b, logic [15:0] r, logic [15:0] c,
                                         logic [15:0] ch, logic [31:0] data);
        in_item_t e;
        e.in_batch   = b;
        e.in_row     = r;
        e.in_col     = c;
        e.in_channel = ch;
        e.element_in = data;
        return e;
    endfunction

    // shaped elements land near or inside the output, the rest are raw noise
    function automatic in_item_t random_element(bit shaped);
        in_item_t        e;
        longint unsigned nb;
        longint unsigned bh;
        longint unsigned bw;
        longint unsigned slots;
        longint unsigned rows;
        longint unsigned cols;
        e = {$urandom, $urandom, $urandom};
        if (shaped) begin
            nb    = (offsets.out_batch == 16'd0) ? 64'd1 : 64'(offsets.out_batch);
            bh    = (offsets.block_h == 8'd0) ? 64'd1 : 64'(offsets.block_h);
            bw    = (offsets.layout == LAYOUT_RANK3 || offsets.block_w == 8'd0) ? 64'd1
                    : 64'(offsets.block_w);
            slots = nb * bh * bw;
            rows  = (64'(offsets.out_height) + 64'(offsets.crops[31:16])) / bh + 64'd1;
            cols  = (64'(offsets.out_width) + 64'(offsets.crops[15:0])) / bw + 64'd1;
            e.in_batch   = 16'($urandom_range(32'((slots > 64'd65536) ? 64'd65535
                                                  : slots - 64'd1)));
            e.in_row     = 16'($urandom_range(32'((rows > 64'd65535) ? 64'd65535 : rows)));
            e.in_col     = 16'($urandom_range(32'((cols > 64'd65535) ? 64'd65535 : cols)));
            e.in_channel = 16'($urandom_range(32'(offsets.channels)));
        end
        return e;
    endfunction

    task automatic send_element(in_item_t e);
        elements_if.valid   <= 1'b1;
        elements_if.payload <= e;
        @(posedge clk);
        while (!elements_if.ready)
            @(posedge clk);
        offsets.note_element(e);
    endtask

    task automatic drain_results();
        elements_if.valid <= 1'b0;
        while (offsets.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        offsets.set_reg(idx, value);
    endtask

    task automatic apply_config(logic [31:0] layout_v, logic [31:0] nb, logic [31:0] oh,
                                logic [31:0] ow, logic [31:0] cn, logic [31:0] bh,
                                logic [31:0] bw, logic [31:0] crops_v);
        drain_results();
        write_reg(REG_LAYOUT_MODE, layout_v);
        write_reg(REG_OUT_BATCH, nb);
        write_reg(REG_OUT_HEIGHT, oh);
        write_reg(REG_OUT_WIDTH, ow);
        write_reg(REG_CHANNEL_COUNT, cn);
        write_reg(REG_BLOCK_HEIGHT, bh);
        write_reg(REG_BLOCK_WIDTH, bw);
        write_reg(REG_CROP_AMOUNTS, crops_v);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic random_config(int kind);
        case (kind)
            0: apply_config($urandom_range(3), $urandom_range(6, 1), $urandom_range(40, 1),
                            $urandom_range(40, 1), $urandom_range(20, 1), $urandom_range(4, 1),
                            $urandom_range(4, 1),
                            {16'($urandom_range(3)), 16'($urandom_range(3))});
            1: apply_config($urandom_range(3), 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                            32'hFF, 32'hFF, $urandom);
            // upper bits beyond each register width carry garbage here
            2: apply_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom);
            default: apply_config($urandom_range(3), 32'd0, 32'd12 * $urandom_range(1),
                                  32'd12, 32'd5, $urandom_range(3), 32'd0,
                                  {16'($urandom_range(2)), 16'($urandom_range(2))});
        endcase
    endtask

    task automatic stream_elements(int count, int noise_pct);
        in_item_t e;
        int       burst_left;
        burst_left = $urandom_range(16, 1);
        for (int k = 0; k < count; k++) begin
            e = random_element($urandom_range(99) >= noise_pct);
            if (sender_idle && burst_left == 0) begin
                elements_if.valid <= 1'b0;
                repeat ($urandom_range(10, 1)) @(posedge clk);
                burst_left = $urandom_range(16, 1);
            end
            send_element(e);
            if (burst_left > 0)
                burst_left--;
        end
    endtask

    initial
    begin : receiver
        int unsigned tick;
        logic [7:0]  mask;
        int          hold_left;
        results_if.ready = 1'b0;
        tick      = 0;
        mask      = 8'hFF;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && results_if.valid && results_if.ready)
                offsets.check_result(results_if.payload);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (tick % 32 == 0)
                mask = stall_on ? 8'($urandom) : 8'hFF;
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else
                results_if.ready <= mask[tick[2:0]];
        end
    end

    initial
    begin : stimulus
        int kind;
        cfg_write           = 1'b0;
        cfg_index           = REG_LAYOUT_MODE;
        cfg_data            = '0;
        elements_if.valid   = 1'b0;
        elements_if.payload = '0;
        rst_n               = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration
        send_element(element(16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_0000));
        send_element(element(16'd1, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF));

        apply_config(LAYOUT_NHWC, 2, 4, 4, 3, 2, 2, 32'h0001_0001);
        send_element(element(16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_0000));
        send_element(element(16'd5, 16'd1, 16'd1, 16'd2, 32'hDEAD_BEEF));
        send_element(element(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_element(element(16'd3, 16'd2, 16'd1, 16'd0, 32'h1234_5678));

        // selector three behaves as nhwc
        apply_config(LAYOUT_NHWC_ALIAS, 2, 4, 4, 3, 2, 2, 32'h0001_0001);
        send_element(element(16'd5, 16'd1, 16'd1, 16'd2, 32'hA5A5_A5A5));
        send_element(element(16'd2, 16'd0, 16'd1, 16'd1, 32'h5A5A_5A5A));

        apply_config(LAYOUT_NCHW, 2, 4, 4, 3, 2, 2, 32'h0001_0001);
        send_element(element(16'd5, 16'd1, 16'd1, 16'd2, 32'h0F0F_0F0F));
        send_element(element(16'd6, 16'd2, 16'd0, 16'd1, 32'hF0F0_F0F0));
        send_element(element(16'd1, 16'd1, 16'd2, 16'd2, 32'h8000_0001));

        // rank three ignores column, block width and crop left
        apply_config(LAYOUT_RANK3, 2, 5, 7, 4, 2, 3, 32'h0001_0005);
        send_element(element(16'd3, 16'd1, 16'hFFFF, 16'd3, 32'h0000_0001));
        send_element(element(16'd0, 16'd0, 16'd7, 16'd0, 32'h7FFF_FFFF));
        send_element(element(16'd5, 16'd2, 16'd0, 16'd1, 32'hCAFE_F00D));

        // zero batch count and zero block width count as one
        apply_config(LAYOUT_NHWC, 0, 8, 8, 2, 3, 0, 32'h0000_0000);
        send_element(element(16'd4, 16'd1, 16'd2, 16'd1, 32'h0BAD_CAFE));
        send_element(element(16'd0, 16'd2, 16'd7, 16'd0, 32'h1111_2222));

        // empty output drops everything
        apply_config(LAYOUT_NHWC, 1, 0, 4, 2, 1, 1, 32'h0000_0000);
        send_element(element(16'd0, 16'd0, 16'd0, 16'd0, 32'h3333_4444));
        apply_config(LAYOUT_NCHW, 1, 4, 0, 2, 1, 1, 32'h0000_0000);
        send_element(element(16'd0, 16'd0, 16'd0, 16'd0, 32'h5555_6666));

        // offset wraps past 32 bits
        apply_config(LAYOUT_NHWC, 1, 32'hFFFF, 32'hFFFF, 32'hFFFF, 1, 1, 32'h0000_0000);
        send_element(element(16'd0, 16'hFFFE, 16'hFFFE, 16'hFFFE, 32'h7777_8888));
        send_element(element(16'd0, 16'h1000, 16'h2000, 16'd3, 32'h9999_AAAA));

        for (int p = 0; p < 12; p++) begin
            case (p % 6)
                1:       kind = 2;
                2:       kind = 1;
                5:       kind = 3;
                default: kind = 0;
            endcase
            stall_on    = (p % 4 != 1);
            sender_idle = (p % 4 != 1) && (p != 3);
            random_config(kind);
            // long receiver hold so the pipe fills and backs up the input
            if (p == 3)
                hold_request = 400;
            stream_elements(148, 20);
        end

        drain_results();
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (offsets.errors == 0 && offsets.outstanding() == 0)
            $display("batch_to_space_address_map regression: pass");
        else
            $display("batch_to_space_address_map regression: fail");
        $finish;
    end

    initial
    begin : watchdog
        #1000000;
        $display("batch_to_space_address_map regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
